// ===== src/qbv_pkg.sv =====
// Package for the quaternion-between-vectors pipeline: stage counts, fixed-point
// thresholds, per-phase pipeline payload types and the square-root step.
// Used by quaternion_between_vectors_core and tb_top; it depends on nothing else.
`default_nettype none

package qbv_pkg;

	localparam int ISQ_STEPS  = 32;
	localparam int UDIV_STEPS = 31;
	localparam int QDIV_STEPS = 16;
	localparam int NUM_STAGES = 2 * (ISQ_STEPS + 1) + (UDIV_STEPS + 1) + 3 + (QDIV_STEPS + 1) + 1;

	localparam logic signed [35:0] OPP_THRESH     = -36'sd1072668082;
	localparam logic [63:0]        SHORT_AXIS_Q60 = 64'd1152921504606847;
	localparam logic signed [63:0] ONE_Q30        = 64'sd1073741824;
	localparam logic signed [15:0] QUAT_ONE       = 16'sd16384;
	localparam logic signed [15:0] SAT_POS        = 16'sd32767;
	localparam logic signed [15:0] SAT_NEG        = -16'sd32768;

	typedef struct packed {
		logic [63:0] x;
		logic [63:0] r;
	} isq_t;

	typedef struct packed {
		isq_t            sa;
		isq_t            da;
		logic [2:0][15:0] sv;
		logic [2:0][15:0] dv;
		logic            degen;
	} pb_t;

	typedef struct packed {
		logic [5:0][63:0] rem;
		logic [5:0][30:0] q;
		logic [5:0]       neg;
		logic [1:0][30:0] len;
		logic             degen;
	} pc_t;

	typedef struct packed {
		logic [2:0][63:0] pdot;
		logic [5:0][63:0] pcr;
		logic [2:0][63:0] psq;
		logic [2:0][31:0] su;
		logic             degen;
	} mul_t;

	typedef struct packed {
		logic [65:0]      dot;
		logic [2:0][65:0] cr;
		logic [63:0]      a2z;
		logic [63:0]      a2x;
		logic [2:0][31:0] su;
		logic             degen;
	} add_t;

	typedef struct packed {
		logic [35:0]      cos;
		logic [2:0][35:0] cr;
		logic [63:0]      a2z;
		logic [63:0]      a2x;
		logic [2:0][31:0] su;
		logic             degen;
	} rnd_t;

	typedef struct packed {
		isq_t             sq;
		logic [2:0][35:0] ax;
		logic             opp;
		logic             degen;
	} pe_t;

	typedef struct packed {
		logic [31:0]      d;
		logic [2:0][51:0] rem;
		logic [2:0][15:0] q;
		logic [2:0]       neg;
		logic [2:0]       ovf;
		logic [15:0]      w;
		logic             opp;
		logic             degen;
		logic             zax;
	} pf_t;

	// One digit of the floor integer square root, for the bit weight 4^i.
	function automatic isq_t isqrt_step(isq_t a, int i);
		isq_t        b;
		logic [63:0] bitv;
		logic [63:0] trial;
		bitv  = 64'd1 << (2 * i);
		trial = a.r + bitv;
		if (a.x >= trial) begin
			b.x = a.x - trial;
			b.r = (a.r >> 1) + bitv;
		end else begin
			b.x = a.x;
			b.r = a.r >> 1;
		end
		return b;
	endfunction

endpackage

`default_nettype wire

// ===== src/quaternion_between_vectors_core.sv =====
// Pipelined unit quaternion that rotates a start vector onto a destination vector.
// Depends on qbv_pkg for stage counts, thresholds, payload types and the root step.
//
// Channel | Handshake            | Payload
// in      | in_valid / in_ready  | start_x start_y start_z dest_x dest_y dest_z (Q8.8)
// out     | out_valid / out_ready| quat_w quat_x quat_y quat_z (Q2.14), opposite, degenerate
//
// One item enters per cycle unless a finished item waits at a stalled output.
// The pipeline holds two 32-step square-root pipelines and two restoring divider pipelines
// (31 and 16 steps), one step per stage, plus product, sum, rounding and output stages.
// Reset clears only the valid bits. A stall at the output holds every stage at once.
`default_nettype none

module quaternion_between_vectors_core import qbv_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic signed [15:0] start_x,
	input  wire logic signed [15:0] start_y,
	input  wire logic signed [15:0] start_z,
	input  wire logic signed [15:0] dest_x,
	input  wire logic signed [15:0] dest_y,
	input  wire logic signed [15:0] dest_z,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [15:0]      quat_w,
	output logic signed [15:0]      quat_x,
	output logic signed [15:0]      quat_y,
	output logic signed [15:0]      quat_z,
	output logic                    opposite,
	output logic                    degenerate
);

	logic [NUM_STAGES-1:0] vld_s;
	logic                  adv;

	pb_t  pb_s [ISQ_STEPS+1];
	pb_t  pb_n [ISQ_STEPS];
	pc_t  pc_s [UDIV_STEPS+1];
	pc_t  pc_n [UDIV_STEPS];
	pc_t  pc_in;
	mul_t mul_s, mul_n;
	add_t add_s, add_n;
	rnd_t rnd_s, rnd_n;
	pe_t  pe_s [ISQ_STEPS+1];
	pe_t  pe_n [ISQ_STEPS];
	pe_t  pe_in;
	pf_t  pf_s [QDIV_STEPS+1];
	pf_t  pf_n [QDIV_STEPS];
	pf_t  pf_in;

	logic [31:0]        sn2_c, dn2_c;
	logic               degen_c;
	logic signed [15:0] qw_q, qx_q, qy_q, qz_q;
	logic signed [15:0] qw_n, qx_n, qy_n, qz_n;
	logic               opp_q, deg_q, opp_n;

	assign adv      = !vld_s[NUM_STAGES-1] || out_ready;
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[NUM_STAGES-2:0], in_valid};
		end
	end

	function automatic logic [35:0] rnd30(logic [65:0] x);
		logic        neg;
		logic [65:0] mag;
		logic [35:0] q;
		neg = x[65];
		mag = neg ? (66'd0 - x) : x;
		q   = 36'((mag + 66'd536870912) >> 30);
		return neg ? (36'd0 - q) : q;
	endfunction

	function automatic logic signed [15:0] sat_lane(logic [15:0] q, logic neg, logic ovf);
		logic signed [15:0] res;
		if (ovf) begin
			res = neg ? SAT_NEG : SAT_POS;
		end else if (neg) begin
			res = (q > 16'd32768) ? SAT_NEG : $signed(16'd0 - q);
		end else begin
			res = (q > 16'd32767) ? SAT_POS : $signed(q);
		end
		return res;
	endfunction

	// Squared lengths and first square-root pipeline.
	always_comb begin
		sn2_c   = 32'(start_x) * 32'(start_x) + 32'(start_y) * 32'(start_y)
			+ 32'(start_z) * 32'(start_z);
		dn2_c   = 32'(dest_x) * 32'(dest_x) + 32'(dest_y) * 32'(dest_y)
			+ 32'(dest_z) * 32'(dest_z);
		degen_c = (sn2_c == 32'd0) || (dn2_c == 32'd0);
	end

	for (genvar k = 0; k < ISQ_STEPS; k++) begin : g_pb
		always_comb begin
			pb_n[k]    = pb_s[k];
			pb_n[k].sa = isqrt_step(pb_s[k].sa, ISQ_STEPS - 1 - k);
			pb_n[k].da = isqrt_step(pb_s[k].da, ISQ_STEPS - 1 - k);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pb_s[0].sa.x  <= {4'd0, sn2_c, 28'd0};
			pb_s[0].sa.r  <= '0;
			pb_s[0].da.x  <= {4'd0, dn2_c, 28'd0};
			pb_s[0].da.r  <= '0;
			pb_s[0].sv    <= {start_z, start_y, start_x};
			pb_s[0].dv    <= {dest_z, dest_y, dest_x};
			pb_s[0].degen <= degen_c;
			for (int k = 0; k < ISQ_STEPS; k++) begin
				pb_s[k+1] <= pb_n[k];
			end
		end
	end

	// Normalization: six restoring dividers, one quotient bit per stage.
	always_comb begin
		logic [15:0] v;
		logic [15:0] mag;
		pc_in        = '0;
		pc_in.len[0] = pb_s[ISQ_STEPS].sa.r[30:0];
		pc_in.len[1] = pb_s[ISQ_STEPS].da.r[30:0];
		pc_in.degen  = pb_s[ISQ_STEPS].degen;
		for (int i = 0; i < 6; i++) begin
			v = (i < 3) ? pb_s[ISQ_STEPS].sv[i % 3] : pb_s[ISQ_STEPS].dv[i % 3];
			mag = v[15] ? (16'd0 - v) : v;
			pc_in.neg[i] = v[15];
			pc_in.rem[i] = ({48'd0, mag} << 44)
				+ {34'd0, pc_in.len[(i < 3) ? 0 : 1][30:1]};
		end
	end

	for (genvar k = 0; k < UDIV_STEPS; k++) begin : g_pc
		always_comb begin
			logic [63:0] dsh;
			pc_n[k] = pc_s[k];
			for (int i = 0; i < 6; i++) begin
				dsh = {33'd0, pc_s[k].len[(i < 3) ? 0 : 1]} << (UDIV_STEPS - 1 - k);
				if (pc_s[k].rem[i] >= dsh) begin
					pc_n[k].rem[i] = pc_s[k].rem[i] - dsh;
					pc_n[k].q[i][UDIV_STEPS-1-k] = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pc_s[0] <= pc_in;
			for (int k = 0; k < UDIV_STEPS; k++) begin
				pc_s[k+1] <= pc_n[k];
			end
		end
	end

	// Dot, cross and square products of the unit vectors.
	always_comb begin
		logic [31:0]        u [6];
		logic signed [63:0] e [6];
		for (int i = 0; i < 6; i++) begin
			u[i] = pc_s[UDIV_STEPS].neg[i] ? (32'd0 - {1'b0, pc_s[UDIV_STEPS].q[i]})
				: {1'b0, pc_s[UDIV_STEPS].q[i]};
			e[i] = 64'($signed(u[i]));
		end
		for (int i = 0; i < 3; i++) begin
			mul_n.pdot[i] = e[i] * e[i+3];
			mul_n.psq[i]  = e[i] * e[i];
			mul_n.su[i]   = u[i];
		end
		mul_n.pcr[0] = e[1] * e[5];
		mul_n.pcr[1] = e[2] * e[4];
		mul_n.pcr[2] = e[2] * e[3];
		mul_n.pcr[3] = e[0] * e[5];
		mul_n.pcr[4] = e[0] * e[4];
		mul_n.pcr[5] = e[1] * e[3];
		mul_n.degen  = pc_s[UDIV_STEPS].degen;
	end

	always_comb begin
		add_n.dot = 66'($signed(mul_s.pdot[0])) + 66'($signed(mul_s.pdot[1]))
			+ 66'($signed(mul_s.pdot[2]));
		for (int j = 0; j < 3; j++) begin
			add_n.cr[j] = 66'($signed(mul_s.pcr[2*j])) - 66'($signed(mul_s.pcr[2*j+1]));
		end
		add_n.a2z   = mul_s.psq[1] + mul_s.psq[0];
		add_n.a2x   = mul_s.psq[2] + mul_s.psq[1];
		add_n.su    = mul_s.su;
		add_n.degen = mul_s.degen;
	end

	always_comb begin
		rnd_n.cos = rnd30(add_s.dot);
		for (int j = 0; j < 3; j++) begin
			rnd_n.cr[j] = rnd30(add_s.cr[j]);
		end
		rnd_n.a2z   = add_s.a2z;
		rnd_n.a2x   = add_s.a2x;
		rnd_n.su    = add_s.su;
		rnd_n.degen = add_s.degen;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mul_s <= mul_n;
			add_s <= add_n;
			rnd_s <= rnd_n;
		end
	end

	// Path choice and the second square-root pipeline (s or the half-turn axis length).
	always_comb begin
		logic [35:0] s36 [3];
		logic [63:0] tt;
		for (int i = 0; i < 3; i++) begin
			s36[i] = 36'($signed(rnd_s.su[i]));
		end
		tt          = 64'(($signed(64'($signed(rnd_s.cos))) + ONE_Q30) <<< 1);
		pe_in.opp   = $signed(rnd_s.cos) < OPP_THRESH;
		pe_in.degen = rnd_s.degen;
		pe_in.sq.r  = '0;
		if (!pe_in.opp) begin
			pe_in.ax   = rnd_s.cr;
			pe_in.sq.x = tt << 30;
		end else if (rnd_s.a2z < SHORT_AXIS_Q60) begin
			pe_in.ax[0] = '0;
			pe_in.ax[1] = 36'd0 - s36[2];
			pe_in.ax[2] = s36[1];
			pe_in.sq.x  = rnd_s.a2x;
		end else begin
			pe_in.ax[0] = 36'd0 - s36[1];
			pe_in.ax[1] = s36[0];
			pe_in.ax[2] = '0;
			pe_in.sq.x  = rnd_s.a2z;
		end
	end

	for (genvar k = 0; k < ISQ_STEPS; k++) begin : g_pe
		always_comb begin
			pe_n[k]    = pe_s[k];
			pe_n[k].sq = isqrt_step(pe_s[k].sq, ISQ_STEPS - 1 - k);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pe_s[0] <= pe_in;
			for (int k = 0; k < ISQ_STEPS; k++) begin
				pe_s[k+1] <= pe_n[k];
			end
		end
	end

	// Component division by the root, with early overflow detection for saturation.
	always_comb begin
		logic [31:0] root;
		logic [35:0] mag;
		root        = pe_s[ISQ_STEPS].sq.r[31:0];
		pf_in       = '0;
		pf_in.opp   = pe_s[ISQ_STEPS].opp;
		pf_in.degen = pe_s[ISQ_STEPS].degen;
		pf_in.zax   = pf_in.opp && (root == 32'd0);
		pf_in.d     = (!pf_in.opp && (root == 32'd0)) ? 32'd1 : root;
		pf_in.w     = pf_in.opp ? 16'd0 : 16'(({1'b0, root} + 33'd65536) >> 17);
		for (int i = 0; i < 3; i++) begin
			pf_in.neg[i] = pe_s[ISQ_STEPS].ax[i][35];
			mag = pf_in.neg[i] ? (36'd0 - pe_s[ISQ_STEPS].ax[i]) : pe_s[ISQ_STEPS].ax[i];
			pf_in.rem[i] = {2'd0, mag, 14'd0} + {21'd0, pf_in.d[31:1]};
			pf_in.ovf[i] = pf_in.rem[i] >= ({20'd0, pf_in.d} << 16);
		end
	end

	for (genvar k = 0; k < QDIV_STEPS; k++) begin : g_pf
		always_comb begin
			logic [51:0] dsh;
			pf_n[k] = pf_s[k];
			dsh     = {20'd0, pf_s[k].d} << (QDIV_STEPS - 1 - k);
			for (int i = 0; i < 3; i++) begin
				if (pf_s[k].rem[i] >= dsh) begin
					pf_n[k].rem[i] = pf_s[k].rem[i] - dsh;
					pf_n[k].q[i][QDIV_STEPS-1-k] = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pf_s[0] <= pf_in;
			for (int k = 0; k < QDIV_STEPS; k++) begin
				pf_s[k+1] <= pf_n[k];
			end
		end
	end

	// Saturation and the identity and fallback-axis overrides.
	always_comb begin
		if (pf_s[QDIV_STEPS].degen) begin
			qw_n  = QUAT_ONE;
			qx_n  = '0;
			qy_n  = '0;
			qz_n  = '0;
			opp_n = 1'b0;
		end else if (pf_s[QDIV_STEPS].zax) begin
			qw_n  = '0;
			qx_n  = QUAT_ONE;
			qy_n  = '0;
			qz_n  = '0;
			opp_n = 1'b1;
		end else begin
			qw_n  = (pf_s[QDIV_STEPS].w > 16'd32767) ? SAT_POS : $signed(pf_s[QDIV_STEPS].w);
			qx_n  = sat_lane(pf_s[QDIV_STEPS].q[0], pf_s[QDIV_STEPS].neg[0],
				pf_s[QDIV_STEPS].ovf[0]);
			qy_n  = sat_lane(pf_s[QDIV_STEPS].q[1], pf_s[QDIV_STEPS].neg[1],
				pf_s[QDIV_STEPS].ovf[1]);
			qz_n  = sat_lane(pf_s[QDIV_STEPS].q[2], pf_s[QDIV_STEPS].neg[2],
				pf_s[QDIV_STEPS].ovf[2]);
			opp_n = pf_s[QDIV_STEPS].opp;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			qw_q  <= qw_n;
			qx_q  <= qx_n;
			qy_q  <= qy_n;
			qz_q  <= qz_n;
			opp_q <= opp_n;
			deg_q <= pf_s[QDIV_STEPS].degen;
		end
	end

	assign out_valid  = vld_s[NUM_STAGES-1];
	assign quat_w     = qw_q;
	assign quat_x     = qx_q;
	assign quat_y     = qy_q;
	assign quat_z     = qz_q;
	assign opposite   = opp_q;
	assign degenerate = deg_q;

	// A degenerate item always yields the identity and never the half turn.
	a_degen_identity: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |-> quat_w == QUAT_ONE && quat_x == 16'sd0 && !opposite)
		else $error("degenerate item without identity result");

	// The half turn always has a zero scalar part.
	a_opp_w_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && opposite |-> quat_w == 16'sd0)
		else $error("half turn with nonzero scalar part");

	// On the normal path the scalar part is strictly positive.
	a_normal_w_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !opposite && !degenerate |-> quat_w > 16'sd0)
		else $error("normal path with nonpositive scalar part");

	// The input side only stalls while a finished item waits at the output.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without an output stall");

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for quaternion_between_vectors_core: a built-in
// integer predictor computes each expected quaternion from the input vectors.
// Depends on the core RTL and qbv_pkg; directed and random vector pairs, random idling and output stalls.
`default_nettype none

module tb_top;
	import qbv_pkg::*;

	typedef struct {
		logic signed [15:0] w;
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
		logic               opp;
		logic               degen;
	} quat_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [15:0] start_x = '0, start_y = '0, start_z = '0;
	logic signed [15:0] dest_x = '0, dest_y = '0, dest_z = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [15:0] quat_w, quat_x, quat_y, quat_z;
	logic opposite, degenerate;

	quat_res_t expected_quats[$];
	int mismatches = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	always #5 clk = ~clk;

	quaternion_between_vectors_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.start_x(start_x), .start_y(start_y), .start_z(start_z),
		.dest_x(dest_x), .dest_y(dest_y), .dest_z(dest_z),
		.out_valid(out_valid), .out_ready(out_ready),
		.quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
		.opposite(opposite), .degenerate(degenerate)
	);

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic longint round_div(longint num, longint unsigned den);
		longint unsigned mag, q;
		mag = (num < 0) ? 64'(-num) : 64'(num);
		q = (mag + den / 2) / den;
		return (num < 0) ? -longint'(q) : longint'(q);
	endfunction

	function automatic logic signed [15:0] clamp16(longint v);
		if (v > 32767)
			return 16'sd32767;
		if (v < -32768)
			return -16'sd32768;
		return 16'(v);
	endfunction

	function automatic quat_res_t rotation_between(logic signed [15:0] s[3],
			logic signed [15:0] d[3]);
		quat_res_t res;
		longint sv[3], dv[3], su[3], du[3], ax[3];
		longint unsigned sn2, dn2, slen, dlen, a2, alen, t, sq;
		longint cosq, qw, qx, qy, qz;
		sn2 = 0;
		dn2 = 0;
		qw = 16384; qx = 0; qy = 0; qz = 0;
		res.opp = 1'b0;
		res.degen = 1'b0;
		for (int i = 0; i < 3; i++) begin
			sv[i] = s[i];
			dv[i] = d[i];
			sn2 += sv[i] * sv[i];
			dn2 += dv[i] * dv[i];
		end
		if (sn2 == 0 || dn2 == 0) begin
			res.degen = 1'b1;
		end else begin
			slen = int_sqrt(sn2 << 28);
			dlen = int_sqrt(dn2 << 28);
			for (int i = 0; i < 3; i++) begin
				su[i] = round_div(sv[i] * (64'sd1 <<< 44), slen);
				du[i] = round_div(dv[i] * (64'sd1 <<< 44), dlen);
			end
			cosq = round_div(su[0] * du[0] + su[1] * du[1] + su[2] * du[2], ONE_Q30);
			if (cosq < -64'sd1073741824 + 64'sd1073742) begin
				res.opp = 1'b1;
				ax[0] = -su[1]; ax[1] = su[0]; ax[2] = 0;
				a2 = ax[0] * ax[0] + ax[1] * ax[1];
				if (a2 < SHORT_AXIS_Q60) begin
					ax[0] = 0; ax[1] = -su[2]; ax[2] = su[1];
					a2 = ax[1] * ax[1] + ax[2] * ax[2];
				end
				alen = int_sqrt(a2);
				qw = 0;
				if (alen == 0) begin
					qx = 16384;
				end else begin
					qx = round_div(ax[0] * 16384, alen);
					qy = round_div(ax[1] * 16384, alen);
					qz = round_div(ax[2] * 16384, alen);
				end
			end else begin
				ax[0] = round_div(su[1] * du[2] - su[2] * du[1], ONE_Q30);
				ax[1] = round_div(su[2] * du[0] - su[0] * du[2], ONE_Q30);
				ax[2] = round_div(su[0] * du[1] - su[1] * du[0], ONE_Q30);
				t = 2 * (ONE_Q30 + cosq);
				sq = int_sqrt(t << 30);
				if (sq == 0)
					sq = 1;
				qw = round_div(longint'(sq), 64'd1 << 17);
				qx = round_div(ax[0] * 16384, sq);
				qy = round_div(ax[1] * 16384, sq);
				qz = round_div(ax[2] * 16384, sq);
			end
		end
		res.w = clamp16(qw);
		res.x = clamp16(qx);
		res.y = clamp16(qy);
		res.z = clamp16(qz);
		return res;
	endfunction

	task automatic send_pair(logic signed [15:0] s[3], logic signed [15:0] d[3]);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		start_x <= s[0]; start_y <= s[1]; start_z <= s[2];
		dest_x <= d[0]; dest_y <= d[1]; dest_z <= d[2];
		in_valid <= 1'b1;
		expected_quats.push_back(rotation_between(s, d));
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
	endtask

	function automatic logic signed [15:0] rand_comp();
		case ($urandom_range(5))
			0: return 16'($urandom);
			1: return 16'sd0;
			2: return 16'($urandom_range(0, 8)) - 16'sd4;
			3: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
			default: return 16'($urandom_range(0, 2047)) - 16'sd1024;
		endcase
	endfunction

	task automatic send_random(int n);
		logic signed [15:0] s[3], d[3];
		for (int k = 0; k < n; k++) begin
			for (int i = 0; i < 3; i++)
				s[i] = rand_comp();
			case ($urandom_range(7))
				0: for (int i = 0; i < 3; i++) d[i] = -s[i];
				1: for (int i = 0; i < 3; i++) d[i] = s[i];
				2: for (int i = 0; i < 3; i++)
					d[i] = -s[i] + 16'($urandom_range(0, 2)) - 16'sd1;
				default: for (int i = 0; i < 3; i++) d[i] = rand_comp();
			endcase
			send_pair(s, d);
		end
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_quats.size() != 0)
			@(negedge clk);
	endtask

	task automatic test_directed();
		send_pair('{16'sh0100, 0, 0}, '{0, 16'sh0100, 0});
		send_pair('{0, 0, 0}, '{1, 2, 3});
		send_pair('{1, 2, 3}, '{0, 0, 0});
		send_pair('{0, 0, 0}, '{0, 0, 0});
		send_pair('{16'sh7fff, 16'sh7fff, 16'sh7fff}, '{16'sh8000, 16'sh8000, 16'sh8000});
		send_pair('{16'sh8000, 0, 0}, '{16'sh7fff, 0, 0});
		send_pair('{0, 0, 16'sh0100}, '{0, 0, -16'sh0100});
		send_pair('{0, 0, 1}, '{0, 1, -16'sh1000});
		send_pair('{16'sh0100, 0, 0}, '{-16'sh0100, 0, 0});
		send_pair('{0, 16'sh0100, 0}, '{0, -16'sh0100, 1});
		send_pair('{1, 1, 1}, '{1, 1, 1});
		send_pair('{16'sh7fff, 0, 0}, '{0, 0, 16'sh7fff});
		send_pair('{-1, -1, -1}, '{16'sh8000, 16'sh7fff, 16'sh8000});
		send_pair('{16'sh5555, 16'shaaaa, 16'sh5555}, '{16'shaaaa, 16'sh5555, 16'shaaaa});
		send_pair('{16'sh0100, 16'sh0001, 0}, '{-16'sh0100, 0, 0});
	endtask

	task automatic test_phase(int idle, int stall, int n);
		send_idle_pct = idle;
		recv_stall_pct = stall;
		send_random(n);
	endtask

	always @(negedge clk)
		out_ready <= ($urandom_range(99) >= recv_stall_pct);

	always @(posedge clk) begin
		quat_res_t e;
		if (arst_n && out_valid && out_ready) begin
			if (expected_quats.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected result item w=%0d x=%0d y=%0d z=%0d",
						quat_w, quat_x, quat_y, quat_z);
			end else begin
				e = expected_quats.pop_front();
				if (quat_w !== e.w || quat_x !== e.x || quat_y !== e.y ||
						quat_z !== e.z || opposite !== e.opp || degenerate !== e.degen) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Mismatch exp %0d %0d %0d %0d o%0b d%0b got %0d %0d %0d %0d o%0b d%0b",
							e.w, e.x, e.y, e.z, e.opp, e.degen, quat_w, quat_x,
							quat_y, quat_z, opposite, degenerate);
				end
			end
		end
	end

	initial begin
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_phase(0, 0, 350);
		wait_drained();
		test_phase(46, 0, 350);
		test_phase(0, 46, 350);
		test_phase(32, 32, 350);
		wait_drained();
		repeat (150) @(negedge clk);
		if (mismatches == 0 && expected_quats.size() == 0)
			$display("quaternion_between_vectors_core verification clean");
		else
			$display("quaternion_between_vectors_core verification failed");
		$finish;
	end

	initial begin
		#2000000;
		$display("quaternion_between_vectors_core verification failed");
		$finish;
	end
endmodule

`default_nettype wire
